// ----- rtl/bpq_pkg.sv -----
// bpq_pkg: shared types, constants and helpers for the bounded priority queue
// used by bpq_cell, bpq_or_tree and bounded_priority_queue; no dependencies
package bpq_pkg;

  // default sizes of the queue and its words
  localparam int DEPTH_DEF     = 1024;
  localparam int KEY_WIDTH_DEF = 32;
  localparam int TAG_WIDTH_DEF = 16;

  // entry count and capacity register width
  localparam int CNT_W = 11;
  localparam logic [CNT_W-1:0] CAPACITY_RESET = 11'd750;

  // register file: one word index bit above the byte offset
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;
  localparam logic [0:0] REG_CAPACITY = 1'b0;

  // fan-in of each level of the duplicate-detect tree
  localparam int OR_RADIX = 16;

  // command codes of an input word
  typedef enum logic [1:0] {
    CMD_PUSH = 2'd0,
    CMD_POP  = 2'd1,
    CMD_PEEK = 2'd2
  } cmd_e;

  // sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CMP,
    ST_TREE,
    ST_APPLY
  } state_t;

  // control broadcast to every cell of the chain
  typedef struct packed {
    logic cmp_en;
    logic push_en;
    logic pop_en;
    logic dup;
  } cell_ctl_t;

  // number of registered levels needed to reduce n bits at OR_RADIX per level
  function automatic int tree_levels(input int n);
    int lv;
    int w;
    lv = 0;
    w  = n;
    while (w > 1) begin
      w  = (w + OR_RADIX - 1) / OR_RADIX;
      lv = lv + 1;
    end
    if (lv == 0) begin
      lv = 1;
    end
    return lv;
  endfunction

endpackage

// ----- rtl/bpq_cell.sv -----
// bpq_cell: one slot of the sorted chain, holds a key, tag and valid flag
// depends on bpq_pkg for the control struct and the count width
module bpq_cell #(
  parameter int KEY_WIDTH = bpq_pkg::KEY_WIDTH_DEF,
  parameter int TAG_WIDTH = bpq_pkg::TAG_WIDTH_DEF,
  parameter int IDX       = 0
) (
  input  logic                        clk,
  input  logic                        rst,
  input  bpq_pkg::cell_ctl_t          ctl,
  input  logic signed [KEY_WIDTH-1:0] new_key,
  input  logic        [TAG_WIDTH-1:0] new_tag,
  input  logic   [bpq_pkg::CNT_W-1:0] limit,
  input  logic signed [KEY_WIDTH-1:0] left_key,
  input  logic        [TAG_WIDTH-1:0] left_tag,
  input  logic                        left_valid,
  input  logic                        left_gt,
  input  logic signed [KEY_WIDTH-1:0] right_key,
  input  logic        [TAG_WIDTH-1:0] right_tag,
  input  logic                        right_valid,
  output logic signed [KEY_WIDTH-1:0] key,
  output logic        [TAG_WIDTH-1:0] tag,
  output logic                        valid,
  output logic                        gt,
  output logic                        eq
);
  import bpq_pkg::*;

  logic signed [KEY_WIDTH-1:0] key_next;
  logic        [TAG_WIDTH-1:0] tag_next;
  logic                        valid_next;
  logic                        keep;
  logic                        ranks_after;

  // slot survives trimming when its place lies below the limit
  assign keep = (32'(IDX) < 32'(limit));

  // lexicographic order: key first, then tag
  assign ranks_after = (key > new_key) || ((key == new_key) && (tag > new_tag));

  // insert, shift towards the tail, or shift towards the head
  always_comb begin
    key_next   = key;
    tag_next   = tag;
    valid_next = valid;
    if (ctl.push_en) begin
      if (!ctl.dup && gt) begin
        if (left_gt) begin
          key_next   = left_key;
          tag_next   = left_tag;
          valid_next = left_valid;
        end else begin
          key_next   = new_key;
          tag_next   = new_tag;
          valid_next = 1'b1;
        end
      end
      valid_next = valid_next && keep;
    end else if (ctl.pop_en) begin
      key_next   = right_key;
      tag_next   = right_tag;
      valid_next = right_valid;
    end
  end

  // slot payload
  always_ff @(posedge clk) begin
    key <= key_next;
    tag <= tag_next;
  end

  // valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= valid_next;
    end
  end

  // compare flags against the broadcast entry
  always_ff @(posedge clk) begin
    if (ctl.cmp_en) begin
      gt <= !valid || ranks_after;
      eq <= valid && (key == new_key) && (tag == new_tag);
    end
  end

endmodule

// ----- rtl/bpq_or_tree.sv -----
// bpq_or_tree: registered OR reduction over the per-cell match flags
// depends on bpq_pkg for the radix and the level count helper
module bpq_or_tree #(
  parameter int WIDTH = bpq_pkg::DEPTH_DEF
) (
  input  logic             clk,
  input  logic [WIDTH-1:0] bits,
  output logic             any
);
  import bpq_pkg::*;

  localparam int LEVELS = tree_levels(WIDTH);
  localparam int PAD_W  = OR_RADIX ** LEVELS;

  logic [PAD_W-1:0] lvl [LEVELS+1];

  // zero padding up to a whole power of the radix
  assign lvl[0] = PAD_W'(bits);

  // one register stage per level
  for (genvar lv = 0; lv < LEVELS; lv++) begin : g_level
    localparam int NO = PAD_W / (OR_RADIX ** (lv + 1));
    logic [NO-1:0] q;
    for (genvar j = 0; j < NO; j++) begin : g_node
      always_ff @(posedge clk) begin
        q[j] <= |lvl[lv][j*OR_RADIX +: OR_RADIX];
      end
    end
    assign lvl[lv+1] = PAD_W'(q);
  end

  assign any = lvl[LEVELS][0];

endmodule

// ----- rtl/bounded_priority_queue.sv -----
// bounded_priority_queue: sorted, capacity-limited queue built as a chain of cells
// one word at a time, taken in ST_IDLE; ST_APPLY answers once the output is free
// pop and peek go straight to ST_APPLY; push first runs ST_CMP and then ST_TREE
//   for L = ceil(log16(DEPTH)) levels of the duplicate-detect OR tree (3 at 1024)
// reset: synchronous, empties the queue and sets capacity to 750; no clearing pass
// depends on bpq_pkg, bpq_cell and bpq_or_tree
module bounded_priority_queue #(
  parameter int DEPTH     = bpq_pkg::DEPTH_DEF,
  parameter int KEY_WIDTH = bpq_pkg::KEY_WIDTH_DEF,
  parameter int TAG_WIDTH = bpq_pkg::TAG_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  // command channel
  input  logic                          cmd_valid,
  output logic                          cmd_ready,
  input  logic [1:0]                    command,
  input  logic signed [KEY_WIDTH-1:0]   key,
  input  logic        [TAG_WIDTH-1:0]   tag,
  // response channel
  output logic                          rsp_valid,
  input  logic                          rsp_ready,
  output logic                          out_valid,
  output logic signed [KEY_WIDTH-1:0]   out_key,
  output logic        [TAG_WIDTH-1:0]   out_tag,
  output logic   [bpq_pkg::CNT_W-1:0]   entry_count,
  output logic                          is_empty,
  // register port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [bpq_pkg::PADDR_W-1:0]   paddr,
  input  logic [bpq_pkg::PDATA_W-1:0]   pwdata,
  output logic [bpq_pkg::PDATA_W-1:0]   prdata,
  output logic                          pready
);
  import bpq_pkg::*;

  localparam int LEVELS = tree_levels(DEPTH);
  localparam int TC_W   = (LEVELS > 1) ? $clog2(LEVELS) : 1;

  state_t                      state;
  state_t                      state_next;
  logic [TC_W-1:0]             tree_cnt;
  logic [1:0]                  cmd_q;
  logic signed [KEY_WIDTH-1:0] key_q;
  logic        [TAG_WIDTH-1:0] tag_q;
  logic [CNT_W-1:0]            count;
  logic [CNT_W-1:0]            count_next;
  logic [CNT_W-1:0]            capacity;
  logic [CNT_W-1:0]            limit;
  logic [CNT_W:0]              grown;
  logic                        out_free;
  logic                        fire;
  logic                        dup;
  logic                        ins;
  logic                        hit;
  cell_ctl_t                   ctl;

  logic signed [KEY_WIDTH-1:0] c_key [DEPTH];
  logic        [TAG_WIDTH-1:0] c_tag [DEPTH];
  logic [DEPTH-1:0]            c_valid;
  logic [DEPTH-1:0]            c_gt;
  logic [DEPTH-1:0]            c_eq;

  // register port, capacity only
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CAPACITY_RESET;
    end else if (psel && penable && pwrite && (paddr[PADDR_W-1:2] == REG_CAPACITY)) begin
      capacity <= pwdata[CNT_W-1:0];
    end
  end

  always_comb begin
    unique case (paddr[PADDR_W-1:2])
      REG_CAPACITY: prdata = PDATA_W'(capacity);
      default:      prdata = '0;
    endcase
  end

  // effective limit, a capacity above the chain length acts as the chain length
  assign limit = (32'(capacity) < 32'(DEPTH)) ? capacity : CNT_W'(DEPTH);

  // sequencer: next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (cmd_valid) begin
          state_next = (command == CMD_PUSH) ? ST_CMP : ST_APPLY;
        end
      end
      ST_CMP: begin
        state_next = ST_TREE;
      end
      ST_TREE: begin
        if (tree_cnt == TC_W'(LEVELS - 1)) begin
          state_next = ST_APPLY;
        end
      end
      ST_APPLY: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // sequencer: outputs
  assign out_free = !rsp_valid || rsp_ready;

  always_comb begin
    cmd_ready   = (state == ST_IDLE);
    fire        = (state == ST_APPLY) && out_free;
    ctl.cmp_en  = (state == ST_CMP);
    ctl.push_en = fire && (cmd_q == CMD_PUSH);
    ctl.pop_en  = fire && (cmd_q == CMD_POP) && (count != '0);
    ctl.dup     = dup;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // tree stage counter
  always_ff @(posedge clk) begin
    if (rst) begin
      tree_cnt <= '0;
    end else if (state == ST_TREE) begin
      tree_cnt <= tree_cnt + TC_W'(1);
    end else begin
      tree_cnt <= '0;
    end
  end

  // command word capture
  always_ff @(posedge clk) begin
    if (cmd_valid && cmd_ready) begin
      cmd_q <= command;
      key_q <= key;
      tag_q <= tag;
    end
  end

  // chain of cells, head at index 0
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic signed [KEY_WIDTH-1:0] lk;
    logic        [TAG_WIDTH-1:0] lt;
    logic                        lv;
    logic                        lg;
    logic signed [KEY_WIDTH-1:0] rk;
    logic        [TAG_WIDTH-1:0] rt;
    logic                        rv;

    if (i == 0) begin : g_head
      assign lk = '0;
      assign lt = '0;
      assign lv = 1'b0;
      assign lg = 1'b0;
    end else begin : g_left
      assign lk = c_key[i-1];
      assign lt = c_tag[i-1];
      assign lv = c_valid[i-1];
      assign lg = c_gt[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign rk = '0;
      assign rt = '0;
      assign rv = 1'b0;
    end else begin : g_right
      assign rk = c_key[i+1];
      assign rt = c_tag[i+1];
      assign rv = c_valid[i+1];
    end

    bpq_cell #(
      .KEY_WIDTH (KEY_WIDTH),
      .TAG_WIDTH (TAG_WIDTH),
      .IDX       (i)
    ) u_cell (
      .clk         (clk),
      .rst         (rst),
      .ctl         (ctl),
      .new_key     (key_q),
      .new_tag     (tag_q),
      .limit       (limit),
      .left_key    (lk),
      .left_tag    (lt),
      .left_valid  (lv),
      .left_gt     (lg),
      .right_key   (rk),
      .right_tag   (rt),
      .right_valid (rv),
      .key         (c_key[i]),
      .tag         (c_tag[i]),
      .valid       (c_valid[i]),
      .gt          (c_gt[i]),
      .eq          (c_eq[i])
    );
  end

  // duplicate detect over all cells
  bpq_or_tree #(
    .WIDTH (DEPTH)
  ) u_dup (
    .clk  (clk),
    .bits (c_eq),
    .any  (dup)
  );

  // a push lands when it is new and the tail cell is empty or ranks after it
  assign ins   = !dup && c_gt[DEPTH-1];
  assign grown = {1'b0, count} + (CNT_W + 1)'(ins);
  assign hit   = ((cmd_q == CMD_POP) || (cmd_q == CMD_PEEK)) && (count != '0);

  // entry count update
  always_comb begin
    count_next = count;
    case (cmd_q)
      CMD_PUSH: count_next = (grown > {1'b0, limit}) ? limit : grown[CNT_W-1:0];
      CMD_POP:  count_next = (count != '0) ? count - CNT_W'(1) : count;
      default:  count_next = count;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (fire) begin
      count <= count_next;
    end
  end

  // response word register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (fire) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_valid   <= hit;
      out_key     <= hit ? c_key[0] : '0;
      out_tag     <= hit ? c_tag[0] : '0;
      entry_count <= count_next;
      is_empty    <= (count_next == '0);
    end
  end

endmodule

// ----- dv/tb_bounded_priority_queue.sv -----
`timescale 1ns / 1ps
// tb_bounded_priority_queue: self-checking testbench for the bounded priority queue
// holds a shadow sorted queue in a small class; depends on bpq_pkg and the rtl top
module tb_bounded_priority_queue;
  import bpq_pkg::*;

  localparam int QDEPTH = DEPTH_DEF;
  localparam int KW = KEY_WIDTH_DEF;
  localparam int TW = TAG_WIDTH_DEF;
  localparam int LIMIT_CYCLES = 400000;
  // command code that the block treats as a no-op
  localparam logic [1:0] CMD_NONE = 2'd3;

  typedef struct {
    logic                 hit;
    logic signed [KW-1:0] key;
    logic [TW-1:0]        tag;
    logic [CNT_W-1:0]     count;
    logic                 empty;
  } reply_t;

  // shadow queue: sorted by key then tag, best at index 0
  class queue_tracker;
    logic signed [KW-1:0] shadow_key[QDEPTH];
    logic [TW-1:0]        shadow_tag[QDEPTH];
    int unsigned          held;
    int unsigned          cap;
    reply_t               replies_due[$];
    int                   errors;

    function new();
      held   = 0;
      cap    = CAPACITY_RESET;
      errors = 0;
    endfunction

    function void set_capacity(int unsigned c);
      cap = c;
    endfunction

    // insert in order, skip an identical pair, then trim to capacity
    function void insert_entry(logic signed [KW-1:0] k, logic [TW-1:0] t);
      int unsigned p;
      int unsigned j;
      int unsigned lim;
      bit dup;
      p   = 0;
      dup = 0;
      while (p < held) begin
        if (shadow_key[p] == k && shadow_tag[p] == t) begin
          dup = 1;
          break;
        end
        if (k < shadow_key[p] || (k == shadow_key[p] && t < shadow_tag[p])) break;
        p++;
      end
      if (!dup && p < QDEPTH) begin
        j = (held < QDEPTH) ? held : QDEPTH - 1;
        while (j > p) begin
          shadow_key[j] = shadow_key[j-1];
          shadow_tag[j] = shadow_tag[j-1];
          j--;
        end
        shadow_key[p] = k;
        shadow_tag[p] = t;
        if (held < QDEPTH) held++;
      end
      lim = (cap < QDEPTH) ? cap : QDEPTH;
      if (held > lim) held = lim;
    endfunction

    // work out the reply to an accepted word and queue it
    function void note_command(logic [1:0] c, logic signed [KW-1:0] k, logic [TW-1:0] t);
      reply_t r;
      int unsigned j;
      r.hit = 1'b0;
      r.key = '0;
      r.tag = '0;
      case (c) inside
        CMD_PUSH: begin
          insert_entry(k, t);
        end
        CMD_POP, CMD_PEEK: begin
          if (held > 0) begin
            r.hit = 1'b1;
            r.key = shadow_key[0];
            r.tag = shadow_tag[0];
            if (c == CMD_POP) begin
              for (j = 1; j < held; j++) begin
                shadow_key[j-1] = shadow_key[j];
                shadow_tag[j-1] = shadow_tag[j];
              end
              held--;
            end
          end
        end
        default: ;
      endcase
      r.count = held[CNT_W-1:0];
      r.empty = (held == 0);
      replies_due.insert(replies_due.size(), r);
    endfunction

    // compare one reply with the oldest one due
    function void check_reply(reply_t got);
      reply_t exp;
      if (replies_due.size() == 0) begin
        $display("%0t: unexpected reply valid=%0b key=%0d tag=%0h count=%0d empty=%0b",
                 $time, got.hit, got.key, got.tag, got.count, got.empty);
        errors++;
        return;
      end
      exp = replies_due.pop_front();
      if (got.hit !== exp.hit || got.key !== exp.key || got.tag !== exp.tag ||
          got.count !== exp.count || got.empty !== exp.empty) begin
        $display("%0t: reply mismatch, expected valid=%0b key=%0d tag=%0h count=%0d empty=%0b",
                 $time, exp.hit, exp.key, exp.tag, exp.count, exp.empty);
        $display("%0t:                 actual   valid=%0b key=%0d tag=%0h count=%0d empty=%0b",
                 $time, got.hit, got.key, got.tag, got.count, got.empty);
        errors++;
      end
    endfunction
  endclass

  logic                 clk;
  logic                 rst;
  logic                 cmd_valid;
  logic                 cmd_ready;
  logic [1:0]           command;
  logic signed [KW-1:0] key;
  logic [TW-1:0]        tag;
  logic                 rsp_valid;
  logic                 rsp_ready;
  logic                 out_valid;
  logic signed [KW-1:0] out_key;
  logic [TW-1:0]        out_tag;
  logic [CNT_W-1:0]     entry_count;
  logic                 is_empty;
  logic                 psel;
  logic                 penable;
  logic                 pwrite;
  logic [PADDR_W-1:0]   paddr;
  logic [PDATA_W-1:0]   pwdata;
  logic [PDATA_W-1:0]   prdata;
  logic                 pready;

  queue_tracker tracker;
  int send_idle;
  int recv_stall;
  int unsigned cycles;

  bounded_priority_queue dut (
    .clk         (clk),
    .rst         (rst),
    .cmd_valid   (cmd_valid),
    .cmd_ready   (cmd_ready),
    .command     (command),
    .key         (key),
    .tag         (tag),
    .rsp_valid   (rsp_valid),
    .rsp_ready   (rsp_ready),
    .out_valid   (out_valid),
    .out_key     (out_key),
    .out_tag     (out_tag),
    .entry_count (entry_count),
    .is_empty    (is_empty),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  // clock
  always #5 clk = ~clk;

  // run limit
  always @(posedge clk) begin
    cycles++;
    if (cycles >= LIMIT_CYCLES) begin
      $display("[bounded_priority_queue] ERROR");
      $finish;
    end
  end

  // response side back-pressure
  always @(negedge clk) begin
    rsp_ready <= ($urandom_range(99) >= recv_stall);
  end

  // reply monitor
  always @(posedge clk) begin
    if (!rst && rsp_valid && rsp_ready) begin
      tracker.check_reply('{out_valid, out_key, out_tag, entry_count, is_empty});
    end
  end

  // offer one word, with random gaps ahead of it, and wait for acceptance
  task automatic send_word(input logic [1:0] c, input logic signed [KW-1:0] k,
                           input logic [TW-1:0] t);
    @(negedge clk);
    while ($urandom_range(99) < send_idle) begin
      cmd_valid <= 1'b0;
      @(negedge clk);
    end
    cmd_valid <= 1'b1;
    command   <= c;
    key       <= k;
    tag       <= t;
    do @(posedge clk); while (!cmd_ready);
    tracker.note_command(c, k, t);
  endtask

  // random word: mostly pushes or mostly pops by phase, keys clustered or spread
  task automatic send_random(input int push_pct, input int cluster_pct);
    logic [1:0]           c;
    logic signed [KW-1:0] k;
    logic [TW-1:0]        t;
    int                   r;
    int                   s;
    r = $urandom_range(99);
    if (r < push_pct) c = CMD_PUSH;
    else if (r < push_pct + 2) c = CMD_NONE;
    else if ($urandom_range(2) == 0) c = CMD_PEEK;
    else c = CMD_POP;
    s = $urandom_range(99);
    if (s < cluster_pct) begin
      // narrow range so ties and duplicates are common
      r = $urandom_range(8);
      k = r - 4;
      t = TW'($urandom_range(3));
    end else if (s < cluster_pct + 6) begin
      case ($urandom_range(3))
        0: k = {1'b1, {(KW-1){1'b0}}};
        1: k = {1'b0, {(KW-1){1'b1}}};
        2: k = -1;
        default: k = 0;
      endcase
      case ($urandom_range(2))
        0: t = '0;
        1: t = '1;
        default: t = TW'($urandom);
      endcase
    end else begin
      k = $urandom;
      t = TW'($urandom);
    end
    send_word(c, k, t);
  endtask

  // let every reply come back before touching the register
  task automatic drain();
    @(negedge clk);
    cmd_valid <= 1'b0;
    while (tracker.replies_due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // register write then read back
  task automatic write_capacity(input int unsigned c);
    logic [PDATA_W-1:0] rd;
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {REG_CAPACITY, 2'b00};
    pwdata  <= c;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    tracker.set_capacity(c & ((1 << CNT_W) - 1));
    @(negedge clk);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rd = prdata;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (rd[CNT_W-1:0] !== c[CNT_W-1:0]) begin
      $display("%0t: capacity read back expected %0d got %0d", $time, c[CNT_W-1:0],
               rd[CNT_W-1:0]);
      tracker.errors++;
    end
  endtask

  task automatic run_phase(input int unsigned c, input int words, input int push_pct,
                           input int cluster_pct, input int s_idle, input int r_stall);
    drain();
    write_capacity(c);
    send_idle  = s_idle;
    recv_stall = r_stall;
    repeat (words) send_random(push_pct, cluster_pct);
  endtask

  initial begin
    tracker    = new();
    clk        = 1'b0;
    rst        = 1'b1;
    cmd_valid  = 1'b0;
    command    = CMD_PUSH;
    key        = '0;
    tag        = '0;
    rsp_ready  = 1'b0;
    psel       = 1'b0;
    penable    = 1'b0;
    pwrite     = 1'b0;
    paddr      = '0;
    pwdata     = '0;
    send_idle  = 0;
    recv_stall = 0;
    cycles     = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: empty reads, no-op, extremes, ties, duplicate, then drain by pops
    send_word(CMD_PEEK, 0, 0);
    send_word(CMD_POP, 0, 0);
    send_word(CMD_NONE, -1, '1);
    send_word(CMD_PUSH, 0, 0);
    send_word(CMD_PUSH, 0, 0);
    send_word(CMD_PUSH, {1'b1, {(KW-1){1'b0}}}, '1);
    send_word(CMD_PUSH, {1'b0, {(KW-1){1'b1}}}, '0);
    send_word(CMD_PUSH, {1'b0, {(KW-1){1'b1}}}, '1);
    send_word(CMD_PUSH, -1, 5);
    send_word(CMD_PUSH, -1, 4);
    send_word(CMD_PUSH, 1, 16'haaaa);
    send_word(CMD_PUSH, 32'sh55555555, 16'h5555);
    send_word(CMD_NONE, 32'sh2aaaaaaa, 16'h5555);
    send_word(CMD_PEEK, 0, 0);
    repeat (9) send_word(CMD_POP, 0, 0);

    // small capacity with clustered keys, no idling
    run_phase(5, 120, 55, 60, 0, 0);
    // zero capacity: every push empties the queue
    run_phase(0, 40, 50, 50, 64, 0);
    // capacity above the store size: fill the store and push past it
    run_phase(2047, 1120, 97, 2, 31, 31);
    // capacity at the store size on a full store
    run_phase(1024, 60, 60, 10, 0, 64);
    // capacity lowered: surplus stays until a push trims it
    drain();
    write_capacity(3);
    send_idle  = 0;
    recv_stall = 0;
    repeat (4) send_word(CMD_POP, 0, 0);
    send_word(CMD_PEEK, 0, 0);
    repeat (100) send_random(40, 60);

    drain();
    if (tracker.errors == 0) begin
      $display("[bounded_priority_queue] OK");
    end else begin
      $display("[bounded_priority_queue] ERROR");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/bpq_pkg.sv
rtl/bpq_cell.sv
rtl/bpq_or_tree.sv
rtl/bounded_priority_queue.sv
dv/tb_bounded_priority_queue.sv
